// File: design/pcdh_pkg.sv
// Package for the pointer click, drag and hover tracker.
// Holds the phase, event and mode codes and the slot and result types.
// No dependencies.
package pcdh_pkg;

  typedef logic signed [31:0] coord_t;

  typedef enum logic [1:0] {
    PH_OUT      = 2'd0,
    PH_DOWN     = 2'd1,
    PH_CLICKED  = 2'd2,
    PH_DISABLED = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_DOWN  = 3'd0,
    EV_UP    = 3'd1,
    EV_MOVE  = 3'd2,
    EV_ENTER = 3'd3,
    EV_EXIT  = 3'd4,
    EV_CLICK = 3'd5,
    EV_DRAG  = 3'd6,
    EV_NONE  = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    MODE_PROCESS = 3'd0,
    MODE_HOVER   = 3'd1,
    MODE_RESET   = 3'd2,
    MODE_ENABLE  = 3'd3,
    MODE_DISABLE = 3'd4,
    MODE_RELEASE = 3'd5
  } mode_t;

  typedef struct packed {
    phase_t phase;
    logic   hovered;
    logic   prev_hovered;
    coord_t last_x;
    coord_t last_y;
  } slot_t;

  typedef struct packed {
    logic [1:0]  fire_count;
    logic        drag_start;
    logic        drag_end;
    coord_t      last_x;
    coord_t      last_y;
    logic [31:0] event_time;
    logic        group_consumed;
    phase_t      slot_phase;
  } result_t;

endpackage

// File: design/pcdh_if.sv
// Request and result channel interfaces of the pointer tracker.
// Plain valid/ready channels; no package dependency.
interface pcdh_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [2:0]         pointer_slot;
  logic [2:0]         hit_event;
  logic               can_hit;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        time_stamp;

  modport source (output valid, mode, pointer_slot, hit_event, can_hit, pos_x, pos_y,
                  time_stamp, input ready);
  modport sink (input valid, mode, pointer_slot, hit_event, can_hit, pos_x, pos_y,
                time_stamp, output ready);
endinterface

interface pcdh_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         fire_count;
  logic               drag_start;
  logic               drag_end;
  logic signed [31:0] last_x;
  logic signed [31:0] last_y;
  logic [31:0]        event_time;
  logic               group_consumed;
  logic [1:0]         slot_phase;

  modport source (output valid, fire_count, drag_start, drag_end, last_x, last_y,
                  event_time, group_consumed, slot_phase, input ready);
  modport sink (input valid, fire_count, drag_start, drag_end, last_x, last_y,
                event_time, group_consumed, slot_phase, output ready);
endinterface

// File: design/pointer_click_drag_hover_tracker_top.sv
// Top level of the pointer click, drag and hover tracker.
// Throughput: one request per cycle while the result channel is not stalled,
// set by one read-modify-write of the addressed slot between the request
// register and the result register.
// Reset (rst_n low, synchronous) clears the slot table, the group flags,
// the listener kind and both channel stages.
module pointer_click_drag_hover_tracker_top #(
  parameter int POINTER_SLOTS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  pcdh_req_if.sink       in_req,
  pcdh_res_if.source     out_res,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_data
);
  import pcdh_pkg::*;

  localparam int IDX_W = (POINTER_SLOTS > 1) ? $clog2(POINTER_SLOTS) : 1;

  slot_t       slot_tbl_r [POINTER_SLOTS];
  logic        dragging_r;
  logic        consumed_r;
  logic [2:0]  kind_r;

  logic        in_valid_r;
  logic [2:0]  mode_r;
  logic [2:0]  slot_id_r;
  logic [2:0]  hit_event_r;
  logic        can_hit_r;
  coord_t      pos_x_r;
  coord_t      pos_y_r;
  logic [31:0] time_stamp_r;

  logic        out_valid_r;
  result_t     res_r;

  logic        advance;
  logic        do_item;
  logic [6:0]  slot_ext;
  logic        in_range;
  logic [IDX_W-1:0] idx;
  slot_t       slot_cur;
  slot_t       slot_nxt;
  logic        dragging_nxt;
  logic        consumed_nxt;
  result_t     res_nxt;

  assign advance      = !out_valid_r || out_res.ready;
  assign in_req.ready = !in_valid_r || advance;
  assign do_item      = in_valid_r && advance;

  assign slot_ext = 7'(slot_id_r);
  assign in_range = slot_ext < 7'(POINTER_SLOTS);
  assign idx      = slot_ext[IDX_W-1:0];
  assign slot_cur = in_range ? slot_tbl_r[idx] : '0;

  pcdh_eval u_eval (
    .mode          (mode_r),
    .in_range      (in_range),
    .hit_event     (hit_event_r),
    .can_hit       (can_hit_r),
    .pos_x         (pos_x_r),
    .pos_y         (pos_y_r),
    .time_stamp    (time_stamp_r),
    .listener_kind (kind_r),
    .slot_cur      (slot_cur),
    .dragging_cur  (dragging_r),
    .consumed_cur  (consumed_r),
    .slot_nxt      (slot_nxt),
    .dragging_nxt  (dragging_nxt),
    .consumed_nxt  (consumed_nxt),
    .res_nxt       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dragging_r  <= 1'b0;
      consumed_r  <= 1'b0;
      kind_r      <= 3'd0;
      for (int i = 0; i < POINTER_SLOTS; i++) begin
        slot_tbl_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        kind_r <= cfg_data;
      end
      if (in_req.ready) begin
        in_valid_r <= in_req.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (do_item) begin
        dragging_r <= dragging_nxt;
        consumed_r <= consumed_nxt;
        if (in_range) begin
          slot_tbl_r[idx] <= slot_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      mode_r       <= in_req.mode;
      slot_id_r    <= in_req.pointer_slot;
      hit_event_r  <= in_req.hit_event;
      can_hit_r    <= in_req.can_hit;
      pos_x_r      <= in_req.pos_x;
      pos_y_r      <= in_req.pos_y;
      time_stamp_r <= in_req.time_stamp;
    end
    if (do_item) begin
      res_r <= res_nxt;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.fire_count     = res_r.fire_count;
  assign out_res.drag_start     = res_r.drag_start;
  assign out_res.drag_end       = res_r.drag_end;
  assign out_res.last_x         = res_r.last_x;
  assign out_res.last_y         = res_r.last_y;
  assign out_res.event_time     = res_r.event_time;
  assign out_res.group_consumed = res_r.group_consumed;
  assign out_res.slot_phase     = res_r.slot_phase;

endmodule

// File: design/pcdh_eval.sv
// Next-state and result logic for one request against one pointer slot.
// Depends on pcdh_pkg.
module pcdh_eval (
  input  logic [2:0]         mode,
  input  logic               in_range,
  input  logic [2:0]         hit_event,
  input  logic               can_hit,
  input  pcdh_pkg::coord_t   pos_x,
  input  pcdh_pkg::coord_t   pos_y,
  input  logic [31:0]        time_stamp,
  input  logic [2:0]         listener_kind,
  input  pcdh_pkg::slot_t    slot_cur,
  input  logic               dragging_cur,
  input  logic               consumed_cur,
  output pcdh_pkg::slot_t    slot_nxt,
  output logic               dragging_nxt,
  output logic               consumed_nxt,
  output pcdh_pkg::result_t  res_nxt
);
  import pcdh_pkg::*;

  event_t ev;
  event_t kind;
  logic   grp_hover;
  logic   change;
  phase_t phase1;
  logic   dend;
  logic   drag1;
  logic   fire_hover;
  logic   fire_hit;
  logic   fire_drag;
  coord_t seed_x;
  coord_t seed_y;

  assign ev   = event_t'(hit_event);
  assign kind = event_t'(listener_kind);

  always_comb begin
    grp_hover = can_hit && slot_cur.hovered;
    change    = slot_cur.prev_hovered != grp_hover;
    seed_x    = (change && grp_hover) ? pos_x : slot_cur.last_x;
    seed_y    = (change && grp_hover) ? pos_y : slot_cur.last_y;

    phase1 = slot_cur.phase;
    if (grp_hover) begin
      if (ev == EV_DOWN) begin
        phase1 = PH_DOWN;
      end else if (ev == EV_UP && slot_cur.phase == PH_DOWN) begin
        phase1 = PH_CLICKED;
      end
    end else if (ev == EV_DOWN || ev == EV_UP) begin
      phase1 = PH_OUT;
    end

    dend  = slot_cur.phase == PH_DOWN && (phase1 == PH_CLICKED || phase1 == PH_OUT)
            && dragging_cur;
    drag1 = dragging_cur && !dend;

    fire_hover = change && ((grp_hover && kind == EV_ENTER) ||
                            (!grp_hover && kind == EV_EXIT));
    fire_hit   = (phase1 == PH_CLICKED && kind == EV_CLICK) ||
                 (grp_hover && ev != EV_NONE && ev == kind);
    fire_drag  = phase1 == PH_DOWN && kind == EV_DRAG && ev == EV_MOVE;

    slot_nxt     = slot_cur;
    dragging_nxt = dragging_cur;
    consumed_nxt = consumed_cur;
    res_nxt      = '0;

    if (in_range) begin
      case (mode_t'(mode))
        MODE_PROCESS: begin
          slot_nxt.hovered = grp_hover;
          slot_nxt.phase   = phase1;
          slot_nxt.last_x  = pos_x;
          slot_nxt.last_y  = pos_y;
          dragging_nxt     = drag1 || fire_drag;
          consumed_nxt     = consumed_cur || fire_hover || fire_hit || fire_drag;
          res_nxt.fire_count = 2'(fire_hover) + 2'(fire_hit) + 2'(fire_drag);
          res_nxt.drag_start = fire_drag && !drag1;
          res_nxt.drag_end   = dend;
          res_nxt.last_x     = seed_x;
          res_nxt.last_y     = seed_y;
          res_nxt.event_time = time_stamp;
        end
        MODE_HOVER: begin
          slot_nxt.hovered = 1'b1;
        end
        MODE_RESET: begin
          if (slot_cur.phase != PH_DISABLED) begin
            consumed_nxt          = 1'b0;
            slot_nxt.prev_hovered = slot_cur.hovered;
            slot_nxt.hovered      = 1'b0;
          end
          if (slot_cur.phase == PH_CLICKED) begin
            slot_nxt.phase = PH_OUT;
          end
        end
        MODE_ENABLE: begin
          slot_nxt.phase = PH_OUT;
        end
        MODE_DISABLE: begin
          slot_nxt.phase = PH_DISABLED;
          consumed_nxt   = 1'b1;
        end
        MODE_RELEASE: begin
          slot_nxt = '0;
        end
        default: begin
        end
      endcase
      res_nxt.slot_phase = slot_nxt.phase;
    end
    res_nxt.group_consumed = consumed_nxt;
  end

endmodule

// File: design/pcdh_checker.sv
// Port-level checks for the pointer tracker, bound to its top level.
// Depends on pcdh_pkg and pointer_click_drag_hover_tracker_top.
module pcdh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_fire_count,
  input logic        out_drag_start,
  input logic        out_drag_end,
  input logic [1:0]  out_slot_phase,
  input logic [31:0] out_event_time
);
  import pcdh_pkg::*;

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_time))
    else $error("Result request dropped or changed while stalled.");

  a_drag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_drag_start && out_drag_end))
    else $error("Drag started and ended by the same request.");

  a_drag_fires: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drag_start |-> out_fire_count != 2'd0)
    else $error("Drag started without a listener firing.");

  a_drag_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drag_start |-> out_slot_phase == PH_DOWN)
    else $error("Drag started on a slot that is not down.");

endmodule

bind pointer_click_drag_hover_tracker_top pcdh_checker u_pcdh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_fire_count (out_res.fire_count),
  .out_drag_start (out_res.drag_start),
  .out_drag_end   (out_res.drag_end),
  .out_slot_phase (out_res.slot_phase),
  .out_event_time (out_res.event_time)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the pointer click, drag and hover tracker: random and directed requests
// are checked against a cycle-free predictor of the slot table held in a scoreboard class.
// Depends on pcdh_pkg, the channel interfaces and pointer_click_drag_hover_tracker_top.

import pcdh_pkg::*;

localparam int SLOT_COUNT = 8;
localparam logic [2:0] MODE_SPARE_A = 3'd6;
localparam logic [2:0] MODE_SPARE_B = 3'd7;

typedef struct packed {
  logic [2:0]  mode;
  logic [2:0]  slot;
  logic [2:0]  hit_event;
  logic        can_hit;
  coord_t      pos_x;
  coord_t      pos_y;
  logic [31:0] time_stamp;
} pointer_req_t;

class tracker_scoreboard;
  phase_t     phase_tab [SLOT_COUNT];
  bit         hov_tab [SLOT_COUNT];
  bit         prev_hov_tab [SLOT_COUNT];
  coord_t     x_tab [SLOT_COUNT];
  coord_t     y_tab [SLOT_COUNT];
  bit         dragging;
  bit         consumed;
  logic [2:0] kind;
  result_t    pending_results [$];
  int         mismatches;

  function new();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      phase_tab[i] = PH_OUT;
      hov_tab[i] = 1'b0;
      prev_hov_tab[i] = 1'b0;
      x_tab[i] = '0;
      y_tab[i] = '0;
    end
    dragging = 1'b0;
    consumed = 1'b0;
    kind = EV_DOWN;
    mismatches = 0;
  endfunction

  function void set_kind(logic [2:0] k);
    kind = k;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void note_request(pointer_req_t r);
    result_t res;
    phase_t  before_ph;
    bit      grp;
    bit      change;
    int      s;
    res = '0;
    s = int'(r.slot);
    case (r.mode)
      MODE_PROCESS: begin
        before_ph = phase_tab[s];
        if (!r.can_hit) hov_tab[s] = 1'b0;
        grp = r.can_hit && hov_tab[s];
        change = (prev_hov_tab[s] != grp);
        if (change && grp) begin
          x_tab[s] = r.pos_x;
          y_tab[s] = r.pos_y;
        end
        if (grp) begin
          if (r.hit_event == EV_DOWN) phase_tab[s] = PH_DOWN;
          else if (r.hit_event == EV_UP && phase_tab[s] == PH_DOWN) phase_tab[s] = PH_CLICKED;
        end else if (r.hit_event == EV_DOWN || r.hit_event == EV_UP) begin
          phase_tab[s] = PH_OUT;
        end
        if (before_ph == PH_DOWN && dragging &&
            (phase_tab[s] == PH_CLICKED || phase_tab[s] == PH_OUT)) begin
          res.drag_end = 1'b1;
          dragging = 1'b0;
        end
        if (change && ((grp && kind == EV_ENTER) || (!grp && kind == EV_EXIT))) begin
          res.fire_count = res.fire_count + 2'd1;
          consumed = 1'b1;
        end
        if ((phase_tab[s] == PH_CLICKED && kind == EV_CLICK) ||
            (grp && r.hit_event != EV_NONE && r.hit_event == kind)) begin
          res.fire_count = res.fire_count + 2'd1;
          consumed = 1'b1;
        end
        if (phase_tab[s] == PH_DOWN && kind == EV_DRAG && r.hit_event == EV_MOVE) begin
          res.fire_count = res.fire_count + 2'd1;
          if (!dragging) begin
            res.drag_start = 1'b1;
            dragging = 1'b1;
          end
          consumed = 1'b1;
        end
        res.last_x = x_tab[s];
        res.last_y = y_tab[s];
        res.event_time = r.time_stamp;
        x_tab[s] = r.pos_x;
        y_tab[s] = r.pos_y;
      end
      MODE_HOVER: hov_tab[s] = 1'b1;
      MODE_RESET: begin
        if (phase_tab[s] != PH_DISABLED) begin
          consumed = 1'b0;
          prev_hov_tab[s] = hov_tab[s];
          hov_tab[s] = 1'b0;
        end
        if (phase_tab[s] == PH_CLICKED) phase_tab[s] = PH_OUT;
      end
      MODE_ENABLE: phase_tab[s] = PH_OUT;
      MODE_DISABLE: begin
        phase_tab[s] = PH_DISABLED;
        consumed = 1'b1;
      end
      MODE_RELEASE: begin
        hov_tab[s] = 1'b0;
        prev_hov_tab[s] = 1'b0;
        phase_tab[s] = PH_OUT;
        x_tab[s] = '0;
        y_tab[s] = '0;
      end
      default: ;
    endcase
    res.group_consumed = consumed;
    res.slot_phase = phase_tab[s];
    pending_results = {pending_results, res};
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result with no request outstanding");
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    check_field("fire_count", 32'(want.fire_count), 32'(got.fire_count));
    check_field("drag_start", 32'(want.drag_start), 32'(got.drag_start));
    check_field("drag_end", 32'(want.drag_end), 32'(got.drag_end));
    check_field("last_x", want.last_x, got.last_x);
    check_field("last_y", want.last_y, got.last_y);
    check_field("event_time", want.event_time, got.event_time);
    check_field("group_consumed", 32'(want.group_consumed), 32'(got.group_consumed));
    check_field("slot_phase", 32'(want.slot_phase), 32'(got.slot_phase));
  endfunction

  function void check_drained();
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  localparam int PHASE_ITEMS = 160;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_LIMIT = 200;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_data;

  pcdh_req_if req_if ();
  pcdh_res_if res_if ();

  pointer_click_drag_hover_tracker_top #(
    .POINTER_SLOTS(SLOT_COUNT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(req_if),
    .out_res(res_if),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  tracker_scoreboard sb;
  bit           idle_on;
  int           sent;
  int           quiet = 0;
  bit           moved;
  pointer_req_t seen_req;
  result_t      seen_res;

  logic [2:0] kind_plan [9] = '{EV_DRAG, EV_DOWN, EV_ENTER, EV_EXIT, EV_CLICK,
                                EV_MOVE, EV_UP, EV_NONE, EV_DRAG};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (req_if.valid && req_if.ready) begin
        seen_req.mode = req_if.mode;
        seen_req.slot = req_if.pointer_slot;
        seen_req.hit_event = req_if.hit_event;
        seen_req.can_hit = req_if.can_hit;
        seen_req.pos_x = req_if.pos_x;
        seen_req.pos_y = req_if.pos_y;
        seen_req.time_stamp = req_if.time_stamp;
        sb.note_request(seen_req);
        moved = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        seen_res.fire_count = res_if.fire_count;
        seen_res.drag_start = res_if.drag_start;
        seen_res.drag_end = res_if.drag_end;
        seen_res.last_x = res_if.last_x;
        seen_res.last_y = res_if.last_y;
        seen_res.event_time = res_if.event_time;
        seen_res.group_consumed = res_if.group_consumed;
        seen_res.slot_phase = phase_t'(res_if.slot_phase);
        sb.check_result(seen_res);
        moved = 1'b1;
      end
      if (cfg_we) begin
        sb.set_kind(cfg_data);
        moved = 1'b1;
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAIL pointer_click_drag_hover_tracker_top");
        $finish;
      end
    end
  end

  initial begin
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  function automatic coord_t any_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic pointer_req_t make_req(logic [2:0] mode, logic [2:0] slot,
                                            logic [2:0] ev, logic can_hit);
    pointer_req_t r;
    r.mode = mode;
    r.slot = slot;
    r.hit_event = ev;
    r.can_hit = can_hit;
    r.pos_x = any_coord();
    r.pos_y = any_coord();
    r.time_stamp = $urandom();
    return r;
  endfunction

  function automatic pointer_req_t random_req();
    return make_req(3'($urandom_range(MODE_PROCESS, MODE_SPARE_B)),
                    3'($urandom_range(0, 7)),
                    3'($urandom_range(EV_DOWN, EV_NONE)),
                    1'($urandom_range(0, 1)));
  endfunction

  // Entered and left at a falling edge; valid is left high after the request goes.
  task automatic send_request(pointer_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= r.mode;
    req_if.pointer_slot <= r.slot;
    req_if.hit_event <= r.hit_event;
    req_if.can_hit <= r.can_hit;
    req_if.pos_x <= r.pos_x;
    req_if.pos_y <= r.pos_y;
    req_if.time_stamp <= r.time_stamp;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    if (r.mode <= MODE_RELEASE) sent++;
  endtask

  task automatic write_kind(logic [2:0] k);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= k;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One frame of a pointer: the group may be cleared, the pointer may hover, then the event.
  task automatic run_frame(logic [2:0] slot, logic [2:0] ev);
    if ($urandom_range(0, 9) != 0) send_request(make_req(MODE_RESET, slot, ev, 1'b1));
    if ($urandom_range(0, 5) != 0) send_request(make_req(MODE_HOVER, slot, ev, 1'b1));
    send_request(make_req(MODE_PROCESS, slot, ev, $urandom_range(0, 7) != 0));
  endtask

  task automatic run_gesture();
    logic [2:0] slot;
    slot = 3'($urandom_range(0, 7));
    run_frame(slot, EV_DOWN);
    repeat ($urandom_range(0, 4)) run_frame(slot, EV_MOVE);
    run_frame(slot, ($urandom_range(0, 5) == 0) ?
                    3'($urandom_range(EV_DOWN, EV_NONE)) : EV_UP);
    case ($urandom_range(0, 11))
      0: send_request(make_req(MODE_RELEASE, slot, EV_NONE, 1'b0));
      1: send_request(make_req(MODE_DISABLE, slot, EV_NONE, 1'b0));
      2: send_request(make_req(MODE_ENABLE, slot, EV_NONE, 1'b0));
      default: ;
    endcase
  endtask

  task automatic run_directed();
    pointer_req_t r;
    r = make_req(MODE_PROCESS, 3'd0, EV_DOWN, 1'b0);
    r.pos_x = 32'sh7fffffff;
    r.pos_y = 32'sh80000000;
    r.time_stamp = 32'hffffffff;
    send_request(r);
    send_request(make_req(MODE_HOVER, 3'd7, EV_NONE, 1'b1));
    r = make_req(MODE_PROCESS, 3'd7, EV_DOWN, 1'b1);
    r.pos_x = 32'sh80000000;
    r.pos_y = 32'sh7fffffff;
    r.time_stamp = '0;
    send_request(r);
    send_request(make_req(MODE_PROCESS, 3'd7, EV_UP, 1'b1));
    send_request(make_req(MODE_RESET, 3'd7, EV_NONE, 1'b1));
    send_request(make_req(MODE_PROCESS, 3'd7, EV_NONE, 1'b1));
    send_request(make_req(MODE_DISABLE, 3'd2, EV_NONE, 1'b1));
    send_request(make_req(MODE_HOVER, 3'd2, EV_NONE, 1'b1));
    send_request(make_req(MODE_PROCESS, 3'd2, EV_UP, 1'b1));
    send_request(make_req(MODE_PROCESS, 3'd2, EV_DOWN, 1'b1));
    send_request(make_req(MODE_DISABLE, 3'd3, EV_NONE, 1'b1));
    send_request(make_req(MODE_RESET, 3'd3, EV_NONE, 1'b1));
    send_request(make_req(MODE_ENABLE, 3'd3, EV_NONE, 1'b1));
    send_request(make_req(MODE_RELEASE, 3'd4, EV_NONE, 1'b1));
    send_request(make_req(MODE_SPARE_A, 3'd5, EV_DOWN, 1'b1));
    send_request(make_req(MODE_SPARE_B, 3'd6, EV_DOWN, 1'b1));
    send_request(make_req(MODE_HOVER, 3'd1, EV_NONE, 1'b1));
    for (int ev = EV_MOVE; ev <= EV_NONE; ev++)
      send_request(make_req(MODE_PROCESS, 3'd1, 3'(ev), 1'b1));
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.mode = '0;
    req_if.pointer_slot = '0;
    req_if.hit_event = '0;
    req_if.can_hit = 1'b0;
    req_if.pos_x = '0;
    req_if.pos_y = '0;
    req_if.time_stamp = '0;
    res_if.ready = 1'b0;
    sb = new();
    idle_on = 1'b1;
    sent = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int i = 0; i < 9; i++) begin
      if (i == 8) idle_on = 1'b0;
      write_kind(kind_plan[i]);
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 3) == 0) send_request(random_req());
        else run_gesture();
      end
    end
    req_if.valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++) @(negedge clk);
    repeat (4) @(negedge clk);
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("PASS pointer_click_drag_hover_tracker_top");
    end else begin
      $display("FAIL pointer_click_drag_hover_tracker_top");
    end
    $finish;
  end
endmodule

// File: pointer_click_drag_hover_tracker_top.f
design/pcdh_pkg.sv
design/pcdh_if.sv
design/pcdh_eval.sv
design/pointer_click_drag_hover_tracker_top.sv
design/pcdh_checker.sv
verif/tb_top.sv
